// File: rtl/looped_waypoint_interpolator_top_macros.svh
// Assertion macros for the looped waypoint interpolator top level.
`ifndef LOOPED_WAYPOINT_INTERPOLATOR_TOP_MACROS_SVH
`define LOOPED_WAYPOINT_INTERPOLATOR_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define LWI_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define LWI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/lwi_pkg.sv
// Package: request/response types, codes and controller types for the interpolator.
`timescale 1ns / 1ps

package lwi_pkg;

    localparam int TIME_W = 32;
    localparam int SEG_W  = 4;

    localparam logic [2:0] OP_TICK    = 3'd0;
    localparam logic [2:0] OP_APPEND  = 3'd1;
    localparam logic [2:0] OP_CLEAR   = 3'd2;
    localparam logic [2:0] OP_RESTART = 3'd3;
    localparam logic [2:0] OP_OFFSET  = 3'd4;

    localparam logic [1:0] ST_POS   = 2'd0;
    localparam logic [1:0] ST_SHORT = 2'd1;
    localparam logic [1:0] ST_ACK   = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic [2:0]        operation;
        logic [31:0]       delta_time;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [31:0]       segment_time;
    } req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic [3:0]        segment_index;
    } rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_MOD,
        S_MODF,
        S_WRD,
        S_WCMP,
        S_RDC,
        S_RDN,
        S_LSTART,
        S_LWAIT,
        S_OFS_RD,
        S_OFS_WR
    } state_t;

    typedef enum logic [1:0] {
        SEL_CUR,
        SEL_NXT,
        SEL_OFS
    } sel_t;

    typedef struct packed {
        logic latch;
        logic exec;
        logic tick_init;
        logic mod_step;
        logic mod_fin;
        logic walk_step;
        logic commit;
        logic cap_p;
        logic md_start;
        logic load_tick;
        logic ofs_wr;
        sel_t pt_sel;
    } cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       count_ge2;
        logic       count_zero;
        logic       mod_last;
        logic       walk_more;
        logic       ofs_last;
        logic       md_done;
    } sts_t;

endpackage

// File: rtl/lwi_muldiv.sv
// Bit-serial unit: floor(mag * num / den), shift-add multiply then restoring divide.
`timescale 1ns / 1ps

module lwi_muldiv #(
    parameter int MAG_BITS = 33
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [MAG_BITS-1:0] mag,
    input  logic [lwi_pkg::TIME_W-1:0] num,
    input  logic [lwi_pkg::TIME_W-1:0] den,
    output logic                done,
    output logic [MAG_BITS-1:0] quot
);

    localparam int TW   = lwi_pkg::TIME_W;
    localparam int PW   = MAG_BITS + TW;
    localparam int CNTW = $clog2(PW);

    logic            busy_reg, busy_next;
    logic            div_reg, div_next;
    logic            done_reg, done_next;
    logic [PW-1:0]   sh_reg, sh_next;
    logic [TW-1:0]   rem_reg, rem_next;
    logic [TW-1:0]   num_reg, num_next;
    logic [TW-1:0]   den_reg;
    logic [MAG_BITS-1:0] mag_reg;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [TW:0]     r2;

    assign r2 = {rem_reg, sh_reg[PW-1]};

    always_comb
    begin
        busy_next = busy_reg;
        div_next  = div_reg;
        done_next = done_reg;
        sh_next   = sh_reg;
        rem_next  = rem_reg;
        num_next  = num_reg;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            div_next  = 1'b0;
            done_next = 1'b0;
            sh_next   = '0;
            rem_next  = '0;
            num_next  = num;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + CNTW'(1);
            if (!div_reg)
            begin
                sh_next  = (sh_reg << 1) + (num_reg[TW-1] ? PW'(mag_reg) : PW'(0));
                num_next = num_reg << 1;
                if (cnt_reg == CNTW'(TW - 1))
                begin
                    div_next = 1'b1;
                    cnt_next = '0;
                end
            end
            else
            begin
                sh_next = sh_reg << 1;
                if (r2 >= {1'b0, den_reg})
                begin
                    rem_next   = TW'(r2 - {1'b0, den_reg});
                    sh_next[0] = 1'b1;
                end
                else
                begin
                    rem_next = r2[TW-1:0];
                end
                if (cnt_reg == CNTW'(PW - 1))
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            div_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            div_reg  <= div_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg  <= sh_next;
        rem_reg <= rem_next;
        num_reg <= num_next;
        cnt_reg <= cnt_next;
        if (start)
        begin
            mag_reg <= mag;
            den_reg <= den;
        end
    end

    assign done = done_reg;
    assign quot = sh_reg[MAG_BITS-1:0];

endmodule

// File: rtl/lwi_dp.sv
// Datapath: waypoint memories, loop state, modulo and walk logic, lerp units, response register.
`timescale 1ns / 1ps

module lwi_dp #(
    parameter int MAX_POINTS = 16,
    parameter int COORD_BITS = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  lwi_pkg::req_t req,
    input  lwi_pkg::cmd_t cmd,
    output lwi_pkg::sts_t sts,
    output lwi_pkg::rsp_t rsp
);

    localparam int CB  = COORD_BITS;
    localparam int TW  = lwi_pkg::TIME_W;
    localparam int IW  = $clog2(MAX_POINTS);
    localparam int CW  = $clog2(MAX_POINTS + 1);
    localparam int LTW = TW + IW;
    localparam int EW  = TW + 1;
    localparam int MW  = $clog2(EW);

    function automatic logic [IW-1:0] next_of(input logic [IW-1:0] i, input logic [CW-1:0] n);
        logic [CW-1:0] inc;
        inc = CW'(i) + CW'(1);
        next_of = (inc >= n) ? '0 : inc[IW-1:0];
    endfunction

    logic [3*CB-1:0] pt_mem [MAX_POINTS];
    logic [TW-1:0]   at_mem [MAX_POINTS];

    lwi_pkg::req_t   req_reg;
    lwi_pkg::rsp_t   rsp_reg, rsp_exec, rsp_tick;
    logic [CW-1:0]   count_reg;
    logic [IW-1:0]   cur_idx_reg;
    logic [TW-1:0]   elapsed_reg;
    logic [LTW-1:0]  lt_reg;

    logic [EW-1:0]   e_reg;
    logic [LTW-1:0]  rem_reg, rem_mod_next;
    logic [MW-1:0]   mcnt_reg;
    logic [IW-1:0]   cur_reg, nxt_reg, ofs_reg, cur_init, pt_addr;
    logic [CW-1:0]   guard_reg;
    logic [TW-1:0]   den_reg, at_q;
    logic [3*CB-1:0] pt_q, p_reg, wr_data, ofs_data, app_data;
    logic [LTW:0]    mod_shift;
    logic            full, do_append, pt_wr, den_zero, all_done;
    logic [IW-1:0]   wr_addr;
    logic [31:0]     pos_a [3];
    logic [31:0]     res_a [3];
    logic [2:0]      md_done;

    assign pos_a[0] = req_reg.pos_x;
    assign pos_a[1] = req_reg.pos_y;
    assign pos_a[2] = req_reg.pos_z;

    assign full      = count_reg >= CW'(MAX_POINTS);
    assign do_append = cmd.exec && (req_reg.operation == lwi_pkg::OP_APPEND) && !full;
    assign cur_init  = (CW'(cur_idx_reg) < count_reg) ? cur_idx_reg : '0;
    assign den_zero  = den_reg == '0;

    assign mod_shift    = {rem_reg, e_reg[EW-1]};
    assign rem_mod_next = (mod_shift >= {1'b0, lt_reg}) ? LTW'(mod_shift - {1'b0, lt_reg})
                                                        : mod_shift[LTW-1:0];

    always_comb
    begin
        unique case (cmd.pt_sel)
            lwi_pkg::SEL_CUR: pt_addr = cur_reg;
            lwi_pkg::SEL_NXT: pt_addr = nxt_reg;
            lwi_pkg::SEL_OFS: pt_addr = ofs_reg;
            default:          pt_addr = cur_reg;
        endcase
    end

    // per-axis lerp
    for (genvar g = 0; g < 3; g++)
    begin : g_axis
        logic signed [CB-1:0] p_a, np_a;
        logic signed [CB:0]   d_a;
        logic [CB:0]          mag_a, q_a;
        logic                 neg_reg;
        logic signed [CB+1:0] sum_a;
        logic signed [63:0]   wide_a;

        assign p_a   = p_reg[g*CB +: CB];
        assign np_a  = pt_q[g*CB +: CB];
        assign d_a   = (CB+1)'(np_a) - (CB+1)'(p_a);
        assign mag_a = d_a[CB] ? (CB+1)'(-d_a) : d_a;

        always_ff @(posedge clk)
        begin
            if (cmd.md_start)
            begin
                neg_reg <= d_a[CB];
            end
        end

        lwi_muldiv #(
            .MAG_BITS(CB + 1)
        ) u_muldiv (
            .clk   (clk),
            .rst_n (rst_n),
            .start (cmd.md_start),
            .mag   (mag_a),
            .num   (elapsed_reg),
            .den   (den_reg),
            .done  (md_done[g]),
            .quot  (q_a)
        );

        assign sum_a = den_zero ? (CB+2)'(p_a)
                     : neg_reg  ? (CB+2)'(p_a) - signed'((CB+2)'(q_a))
                                : (CB+2)'(p_a) + signed'((CB+2)'(q_a));
        assign wide_a   = 64'(sum_a);
        assign res_a[g] = wide_a[31:0];

        assign ofs_data[g*CB +: CB] = pt_q[g*CB +: CB] + CB'(signed'(pos_a[g]));
        assign app_data[g*CB +: CB] = CB'(signed'(pos_a[g]));
    end

    assign all_done = &md_done;

    always_comb
    begin
        rsp_exec        = '0;
        rsp_exec.status = lwi_pkg::ST_ACK;
        unique case (req_reg.operation)
            lwi_pkg::OP_TICK:
            begin
                rsp_exec.status        = lwi_pkg::ST_SHORT;
                rsp_exec.segment_index = lwi_pkg::SEG_W'(cur_idx_reg);
            end
            lwi_pkg::OP_APPEND:
            begin
                rsp_exec.status = full ? lwi_pkg::ST_FULL : lwi_pkg::ST_ACK;
            end
            default:
            begin
                rsp_exec.status = lwi_pkg::ST_ACK;
            end
        endcase
    end

    always_comb
    begin
        rsp_tick.status        = lwi_pkg::ST_POS;
        rsp_tick.out_x         = res_a[0];
        rsp_tick.out_y         = res_a[1];
        rsp_tick.out_z         = res_a[2];
        rsp_tick.segment_index = lwi_pkg::SEG_W'(cur_reg);
    end

    assign pt_wr   = do_append || cmd.ofs_wr;
    assign wr_addr = cmd.ofs_wr ? ofs_reg : count_reg[IW-1:0];
    assign wr_data = cmd.ofs_wr ? ofs_data : app_data;

    always_ff @(posedge clk)
    begin
        if (pt_wr)
        begin
            pt_mem[wr_addr] <= wr_data;
        end
        if (do_append)
        begin
            at_mem[count_reg[IW-1:0]] <= req_reg.segment_time;
        end
        pt_q <= pt_mem[pt_addr];
        at_q <= at_mem[nxt_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            cur_idx_reg <= '0;
            elapsed_reg <= '0;
            lt_reg      <= '0;
        end
        else
        begin
            if (cmd.exec)
            begin
                unique case (req_reg.operation)
                    lwi_pkg::OP_APPEND:
                    begin
                        if (!full)
                        begin
                            lt_reg    <= lt_reg + LTW'(req_reg.segment_time);
                            count_reg <= count_reg + CW'(1);
                        end
                    end
                    lwi_pkg::OP_CLEAR:
                    begin
                        count_reg   <= '0;
                        cur_idx_reg <= '0;
                        elapsed_reg <= '0;
                        lt_reg      <= '0;
                    end
                    lwi_pkg::OP_RESTART:
                    begin
                        cur_idx_reg <= '0;
                        elapsed_reg <= '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.commit)
            begin
                cur_idx_reg <= cur_reg;
                elapsed_reg <= e_reg[TW-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            req_reg <= req;
        end
        if (cmd.exec)
        begin
            rsp_reg <= rsp_exec;
            ofs_reg <= '0;
        end
        if (cmd.load_tick)
        begin
            rsp_reg <= rsp_tick;
        end
        if (cmd.tick_init)
        begin
            e_reg    <= EW'(elapsed_reg) + EW'(req_reg.delta_time);
            cur_reg  <= cur_init;
            rem_reg  <= '0;
            mcnt_reg <= '0;
        end
        if (cmd.mod_step)
        begin
            e_reg    <= e_reg << 1;
            rem_reg  <= rem_mod_next;
            mcnt_reg <= mcnt_reg + MW'(1);
        end
        if (cmd.mod_fin)
        begin
            e_reg     <= (lt_reg == '0) ? '0 : rem_reg[EW-1:0];
            nxt_reg   <= next_of(cur_reg, count_reg);
            guard_reg <= '0;
        end
        if (cmd.walk_step)
        begin
            e_reg     <= e_reg - EW'(at_q);
            cur_reg   <= nxt_reg;
            nxt_reg   <= next_of(nxt_reg, count_reg);
            guard_reg <= guard_reg + CW'(1);
        end
        if (cmd.commit)
        begin
            den_reg <= at_q;
        end
        if (cmd.cap_p)
        begin
            p_reg <= pt_q;
        end
        if (cmd.ofs_wr)
        begin
            ofs_reg <= ofs_reg + IW'(1);
        end
    end

    assign sts.op         = req_reg.operation;
    assign sts.count_ge2  = count_reg >= CW'(2);
    assign sts.count_zero = count_reg == '0;
    assign sts.mod_last   = mcnt_reg == MW'(EW - 1);
    assign sts.walk_more  = (guard_reg < CW'(MAX_POINTS)) && (e_reg > EW'(at_q));
    assign sts.ofs_last   = (CW'(ofs_reg) + CW'(1)) >= count_reg;
    assign sts.md_done    = all_done;

    assign rsp = rsp_reg;

endmodule

// File: rtl/lwi_ctrl.sv
// Controller: sequences each request through the datapath and owns the handshakes.
`timescale 1ns / 1ps

module lwi_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    input  lwi_pkg::sts_t sts,
    output lwi_pkg::cmd_t cmd
);

    lwi_pkg::state_t state_reg, state_next;
    logic            rsp_valid_reg, rsp_valid_next;
    logic            out_free, is_tick;

    assign out_free = !rsp_valid_reg || !rsp_stall;
    assign is_tick  = (sts.op == lwi_pkg::OP_TICK) && sts.count_ge2;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lwi_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = lwi_pkg::S_EXEC;
                end
            end
            lwi_pkg::S_EXEC:
            begin
                if (out_free)
                begin
                    if (is_tick)
                    begin
                        state_next = lwi_pkg::S_MOD;
                    end
                    else if ((sts.op == lwi_pkg::OP_OFFSET) && !sts.count_zero)
                    begin
                        state_next = lwi_pkg::S_OFS_RD;
                    end
                    else
                    begin
                        state_next = lwi_pkg::S_IDLE;
                    end
                end
            end
            lwi_pkg::S_MOD:
            begin
                if (sts.mod_last)
                begin
                    state_next = lwi_pkg::S_MODF;
                end
            end
            lwi_pkg::S_MODF:   state_next = lwi_pkg::S_WRD;
            lwi_pkg::S_WRD:    state_next = lwi_pkg::S_WCMP;
            lwi_pkg::S_WCMP:   state_next = sts.walk_more ? lwi_pkg::S_WRD : lwi_pkg::S_RDC;
            lwi_pkg::S_RDC:    state_next = lwi_pkg::S_RDN;
            lwi_pkg::S_RDN:    state_next = lwi_pkg::S_LSTART;
            lwi_pkg::S_LSTART: state_next = lwi_pkg::S_LWAIT;
            lwi_pkg::S_LWAIT:
            begin
                if (sts.md_done && out_free)
                begin
                    state_next = lwi_pkg::S_IDLE;
                end
            end
            lwi_pkg::S_OFS_RD: state_next = lwi_pkg::S_OFS_WR;
            lwi_pkg::S_OFS_WR: state_next = sts.ofs_last ? lwi_pkg::S_IDLE : lwi_pkg::S_OFS_RD;
            default:           state_next = lwi_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        cmd.pt_sel = lwi_pkg::SEL_CUR;
        unique case (state_reg)
            lwi_pkg::S_IDLE:   cmd.latch = req_valid;
            lwi_pkg::S_EXEC:
            begin
                cmd.tick_init = out_free && is_tick;
                cmd.exec      = out_free && !is_tick;
            end
            lwi_pkg::S_MOD:    cmd.mod_step = 1'b1;
            lwi_pkg::S_MODF:   cmd.mod_fin = 1'b1;
            lwi_pkg::S_WRD:    cmd.pt_sel = lwi_pkg::SEL_CUR;
            lwi_pkg::S_WCMP:
            begin
                cmd.walk_step = sts.walk_more;
                cmd.commit    = !sts.walk_more;
            end
            lwi_pkg::S_RDC:    cmd.pt_sel = lwi_pkg::SEL_CUR;
            lwi_pkg::S_RDN:
            begin
                cmd.pt_sel = lwi_pkg::SEL_NXT;
                cmd.cap_p  = 1'b1;
            end
            lwi_pkg::S_LSTART: cmd.md_start = 1'b1;
            lwi_pkg::S_LWAIT:  cmd.load_tick = sts.md_done && out_free;
            lwi_pkg::S_OFS_RD: cmd.pt_sel = lwi_pkg::SEL_OFS;
            lwi_pkg::S_OFS_WR:
            begin
                cmd.pt_sel = lwi_pkg::SEL_OFS;
                cmd.ofs_wr = 1'b1;
            end
            default:           cmd.pt_sel = lwi_pkg::SEL_CUR;
        endcase
    end

    assign rsp_valid_next = cmd.exec || cmd.load_tick || (rsp_valid_reg && rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lwi_pkg::S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_stall = state_reg != lwi_pkg::S_IDLE;
    assign rsp_valid = rsp_valid_reg;

endmodule

// File: rtl/looped_waypoint_interpolator_top.sv
// Append, clear, restart and unknown codes respond from S_EXEC once the output is free.
// Offset then rewrites each stored point in turn through S_OFS_RD and S_OFS_WR.
// Tick: modulo by the loop total, segment walk, then per-axis multiply and divide;
// a short path (under two points) responds from S_EXEC like the codes above.
// One request at a time; a response may wait in the output register while the next runs.
// Reset (rst_n, async, active low) empties the table and clears index and elapsed time.
`timescale 1ns / 1ps

`include "looped_waypoint_interpolator_top_macros.svh"

module looped_waypoint_interpolator_top #(
    parameter int MAX_POINTS = 16,
    parameter int COORD_BITS = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  lwi_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output lwi_pkg::rsp_t rsp
);

    lwi_pkg::cmd_t cmd;
    lwi_pkg::sts_t sts;

    lwi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    lwi_dp #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .sts   (sts),
        .rsp   (rsp)
    );

    `LWI_ASSERT_NEXT(a_busy_after_req, req_valid && !req_stall, req_stall, "not busy after request")
    `LWI_ASSERT_NOW(a_rsp_from_work, $rose(rsp_valid), $past(req_stall), "response without work")
    `LWI_ASSERT_NOW(a_one_load, cmd.exec, !cmd.load_tick && !cmd.tick_init, "conflicting loads")

endmodule

// File: tb/sv/looped_waypoint_interpolator_top_tb.sv
// Testbench for the looped waypoint interpolator: directed and random requests vs a predictor.
`timescale 1ns / 1ps

module looped_waypoint_interpolator_top_tb;

    localparam int NPTS      = 16;
    localparam int IDLE_MAX  = 4000;
    localparam int HOLD_LEN  = 300;
    localparam int DRAIN_LEN = 250;
    localparam int EXP_DEPTH = 64;
    localparam logic [2:0] OP_BAD5 = 3'd5;
    localparam logic [2:0] OP_BAD6 = 3'd6;
    localparam logic [2:0] OP_BAD7 = 3'd7;

    logic           clk;
    logic           rst_n;
    logic           req_valid;
    logic           req_stall;
    lwi_pkg::req_t  req;
    logic           rsp_valid;
    logic           rsp_stall;
    lwi_pkg::rsp_t  rsp;

    logic signed [31:0] wp_x [NPTS];
    logic signed [31:0] wp_y [NPTS];
    logic signed [31:0] wp_z [NPTS];
    logic [31:0]        wp_time [NPTS];
    int unsigned        wp_count;
    logic [3:0]         wp_cur;
    logic [31:0]        wp_elapsed;
    logic [35:0]        wp_total;

    lwi_pkg::rsp_t exp_fifo [EXP_DEPTH];
    int   exp_wr;
    int   exp_rd;
    int   errors;
    int   idle_cycles;
    bit   no_gaps;
    bit   hold_rsp;

    looped_waypoint_interpolator_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #2 clk = ~clk;

    function automatic int unsigned next_point(int unsigned i);
        return (i + 1 >= wp_count) ? 0 : i + 1;
    endfunction

    function automatic logic [31:0] lerp_coord(logic signed [31:0] p, logic signed [31:0] np,
                                               logic [31:0] num, logic [31:0] den);
        longint            d;
        longint unsigned   mag;
        longint unsigned   s;
        longint            r;
        if (den == 0 || num == 0)
            return p;
        d   = longint'(np) - longint'(p);
        mag = (d < 0) ? longint'(-d) : d;
        s   = (mag * longint'({32'd0, num})) / longint'({32'd0, den});
        r   = (d < 0) ? longint'(p) - longint'(s) : longint'(p) + longint'(s);
        return r[31:0];
    endfunction

    function automatic lwi_pkg::rsp_t predict_waypoint(lwi_pkg::req_t r);
        lwi_pkg::rsp_t o;
        logic [36:0]   e;
        int unsigned   cur;
        int unsigned   nxt;
        o = '0;
        o.status = lwi_pkg::ST_ACK;
        case (r.operation)
            lwi_pkg::OP_TICK: begin
                if (wp_count < 2) begin
                    o.status = lwi_pkg::ST_SHORT;
                    o.segment_index = wp_cur;
                end else begin
                    cur = (wp_cur < wp_count) ? wp_cur : 0;
                    e = {5'd0, wp_elapsed} + {5'd0, r.delta_time};
                    if (wp_total == 0)
                        e = '0;
                    else
                        e = e % {1'b0, wp_total};
                    nxt = next_point(cur);
                    for (int g = 0; g < NPTS && e > {5'd0, wp_time[nxt]}; g++) begin
                        e   = e - {5'd0, wp_time[nxt]};
                        cur = nxt;
                        nxt = next_point(cur);
                    end
                    wp_cur     = cur[3:0];
                    wp_elapsed = e[31:0];
                    o.status = lwi_pkg::ST_POS;
                    o.out_x = lerp_coord(wp_x[cur], wp_x[nxt], wp_elapsed, wp_time[nxt]);
                    o.out_y = lerp_coord(wp_y[cur], wp_y[nxt], wp_elapsed, wp_time[nxt]);
                    o.out_z = lerp_coord(wp_z[cur], wp_z[nxt], wp_elapsed, wp_time[nxt]);
                    o.segment_index = cur[3:0];
                end
            end
            lwi_pkg::OP_APPEND: begin
                if (wp_count >= NPTS) begin
                    o.status = lwi_pkg::ST_FULL;
                end else begin
                    wp_x[wp_count]    = r.pos_x;
                    wp_y[wp_count]    = r.pos_y;
                    wp_z[wp_count]    = r.pos_z;
                    wp_time[wp_count] = r.segment_time;
                    wp_total = wp_total + {4'd0, r.segment_time};
                    wp_count++;
                end
            end
            lwi_pkg::OP_CLEAR: begin
                wp_count   = 0;
                wp_cur     = '0;
                wp_elapsed = '0;
                wp_total   = '0;
            end
            lwi_pkg::OP_RESTART: begin
                wp_cur     = '0;
                wp_elapsed = '0;
            end
            lwi_pkg::OP_OFFSET: begin
                for (int i = 0; i < wp_count; i++) begin
                    wp_x[i] = wp_x[i] + r.pos_x;
                    wp_y[i] = wp_y[i] + r.pos_y;
                    wp_z[i] = wp_z[i] + r.pos_z;
                end
            end
            default: ;
        endcase
        return o;
    endfunction

    task automatic send_request(lwi_pkg::req_t r);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 12);
        @(negedge clk);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req       <= r;
        req_valid <= 1'b1;
        do @(posedge clk); while (req_stall);
        exp_fifo[exp_wr % EXP_DEPTH] = predict_waypoint(r);
        exp_wr++;
    endtask

    task automatic send_op(logic [2:0] op, logic [31:0] dt, logic [31:0] x, logic [31:0] y,
                           logic [31:0] z, logic [31:0] st);
        lwi_pkg::req_t r;
        r.operation    = op;
        r.delta_time   = dt;
        r.pos_x        = x;
        r.pos_y        = y;
        r.pos_z        = z;
        r.segment_time = st;
        send_request(r);
    endtask

    task automatic report(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t mismatch %s: expected %h actual %h", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    // response checker
    always @(posedge clk)
    begin
        lwi_pkg::rsp_t e;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (exp_wr == exp_rd)
            begin
                $display("%0t unexpected response %h", $time, rsp);
                errors++;
            end
            else
            begin
                e = exp_fifo[exp_rd % EXP_DEPTH];
                exp_rd++;
                report("status", e.status, rsp.status);
                report("out_x", e.out_x, rsp.out_x);
                report("out_y", e.out_y, rsp.out_y);
                report("out_z", e.out_z, rsp.out_z);
                report("segment_index", e.segment_index, rsp.segment_index);
            end
        end
    end

    // response-side stall
    initial
    begin
        int n;
        rsp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            n = hold_rsp ? HOLD_LEN : (no_gaps ? 0 : $urandom_range(0, 12));
            hold_rsp = 1'b0;
            if (n > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (n) @(negedge clk);
            end
            rsp_stall <= 1'b0;
            do @(posedge clk); while (!rsp_valid);
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_MAX)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic test_short_path();
        send_op(lwi_pkg::OP_TICK, 32'h0001_0000, 0, 0, 0, 0);
        send_op(lwi_pkg::OP_APPEND, 0, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                32'h0001_0000);
        send_op(lwi_pkg::OP_TICK, 32'h0000_8000, 0, 0, 0, 0);
        send_op(OP_BAD5, '1, '1, '1, '1, '1);
        send_op(OP_BAD6, 0, 0, 0, 0, 0);
        send_op(OP_BAD7, 32'h1234_5678, 0, 0, 0, 0);
    endtask

    task automatic test_basic_loop();
        send_op(lwi_pkg::OP_CLEAR, 0, 0, 0, 0, 0);
        send_op(lwi_pkg::OP_APPEND, 0, 0, 0, 0, 32'h0002_0000);
        send_op(lwi_pkg::OP_APPEND, 0, 32'h000A_0000, 32'hFFF6_0000, 32'h0000_0001,
                32'h0001_0000);
        send_op(lwi_pkg::OP_APPEND, 0, 32'h0005_0000, 32'h0005_0000, 32'hFFFF_0000,
                32'h0000_0000);
        send_op(lwi_pkg::OP_TICK, 32'h0000_4000, 0, 0, 0, 0);
        send_op(lwi_pkg::OP_TICK, 32'h0000_C000, 0, 0, 0, 0);
        send_op(lwi_pkg::OP_TICK, 0, 0, 0, 0, 0);
        send_op(lwi_pkg::OP_TICK, 32'h0003_8000, 0, 0, 0, 0);
        send_op(lwi_pkg::OP_TICK, 32'hFFFF_FFFF, 0, 0, 0, 0);
        send_op(lwi_pkg::OP_RESTART, 0, 0, 0, 0, 0);
        send_op(lwi_pkg::OP_TICK, 32'h0001_0000, 0, 0, 0, 0);
    endtask

    task automatic test_extremes();
        send_op(lwi_pkg::OP_CLEAR, 0, 0, 0, 0, 0);
        send_op(lwi_pkg::OP_APPEND, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                32'hFFFF_FFFF);
        send_op(lwi_pkg::OP_APPEND, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                32'hFFFF_FFFF);
        send_op(lwi_pkg::OP_TICK, 32'hFFFF_FFFE, 0, 0, 0, 0);
        send_op(lwi_pkg::OP_TICK, 32'hFFFF_FFFF, 0, 0, 0, 0);
        send_op(lwi_pkg::OP_OFFSET, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 0);
        send_op(lwi_pkg::OP_TICK, 32'h8000_0000, 0, 0, 0, 0);
        // zero loop total
        send_op(lwi_pkg::OP_CLEAR, 0, 0, 0, 0, 0);
        send_op(lwi_pkg::OP_APPEND, 0, 32'h0001_0000, 0, 0, 0);
        send_op(lwi_pkg::OP_APPEND, 0, 32'h0002_0000, 0, 0, 0);
        send_op(lwi_pkg::OP_TICK, 32'h0001_0000, 0, 0, 0, 0);
    endtask

    task automatic test_table_full();
        send_op(lwi_pkg::OP_CLEAR, 0, 0, 0, 0, 0);
        for (int i = 0; i <= NPTS; i++)
            send_op(lwi_pkg::OP_APPEND, 0, $urandom, $urandom, $urandom,
                    $urandom_range(0, 32'h0004_0000));
        send_op(lwi_pkg::OP_TICK, 32'h0010_0000, 0, 0, 0, 0);
    endtask

    task automatic send_random();
        int          w;
        logic [31:0] t;
        w = $urandom_range(0, 99);
        case ($urandom_range(0, 3))
            0: t = 0;
            1: t = $urandom;
            default: t = $urandom_range(0, 32'h0003_0000);
        endcase
        if (w < 50)
            send_op(lwi_pkg::OP_TICK, t, $urandom, $urandom, $urandom, $urandom);
        else if (w < 76)
            send_op(lwi_pkg::OP_APPEND, $urandom,
                    ($urandom_range(0, 1) ? $urandom : $urandom_range(0, 255)),
                    $urandom, $urandom, t);
        else if (w < 84)
            send_op(lwi_pkg::OP_OFFSET, $urandom, $urandom, $urandom, $urandom, $urandom);
        else if (w < 90)
            send_op(lwi_pkg::OP_RESTART, $urandom, $urandom, $urandom, $urandom, $urandom);
        else if (w < 96)
            send_op(lwi_pkg::OP_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom);
        else
            send_op(3'($urandom_range(5, 7)), $urandom, $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic test_backpressure();
        hold_rsp = 1'b1;
        no_gaps  = 1'b1;
        for (int i = 0; i < 20; i++)
            send_random();
        no_gaps = 1'b0;
    endtask

    task automatic test_random();
        for (int i = 0; i < 334; i++)
        begin
            if (i % 50 == 0)
                no_gaps = $urandom_range(0, 2) == 0;
            send_random();
        end
        no_gaps = 1'b0;
    endtask

    initial
    begin
        clk         = 1'b0;
        rst_n       = 1'b0;
        req_valid   = 1'b0;
        req         = '0;
        errors      = 0;
        idle_cycles = 0;
        exp_wr      = 0;
        exp_rd      = 0;
        no_gaps     = 1'b0;
        hold_rsp    = 1'b0;
        wp_count    = 0;
        wp_cur      = '0;
        wp_elapsed  = '0;
        wp_total    = '0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        test_short_path();
        test_basic_loop();
        test_extremes();
        test_table_full();
        test_backpressure();
        test_random();

        @(negedge clk);
        req_valid <= 1'b0;
        while (exp_wr != exp_rd)
            @(posedge clk);
        repeat (DRAIN_LEN) @(posedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

// File: filelist.f
+incdir+rtl
rtl/lwi_pkg.sv
rtl/lwi_muldiv.sv
rtl/lwi_dp.sv
rtl/lwi_ctrl.sv
rtl/looped_waypoint_interpolator_top.sv
tb/sv/looped_waypoint_interpolator_top_tb.sv
